// File: design/ght_pkg.sv
// Package for the generational handle table: sizes, generation cap and codes.
// Used by generational_handle_table_core; depends on nothing else.
package ght_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned LINK_W = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  localparam logic [30:0]       GEN_CAP   = 31'h7FFF_FFFF;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_CLOSE  = 3'd1,
    MODE_VERIFY = 3'd2,
    MODE_DUP    = 3'd3,
    MODE_INFO   = 3'd4,
    MODE_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_TYPE    = 3'd2,
    ST_RIGHTS  = 3'd3,
    ST_INVALID = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

endpackage

// File: design/generational_handle_table_core.sv
// Generational handle table: slot map of handles with a chained free list.
// Depends on ght_pkg for sizes, the generation cap and the mode and status codes.
//
// Usage notes.
// Three channels, each with valid and ready. The configuration channel carries
// the bit position of the right that permits duplication; it is always ready and
// should be written only while the table is idle. The input channel takes one
// item per operation (create, close, verify, duplicate, info, clear all) and the
// output channel returns exactly one result item for each.
// An accepted item reads its entry and the free-list head entry from the
// synchronous tables as it is accepted; in the execute state it is resolved and
// written back once the output register is free. A clear-all walks every slot
// from the top down, reading the generation of each slot and then writing back
// the generation and the free link, and ends in a finish state that loads its
// result. The block takes one item at a time.
// Reset clears the live marks and forms the free list in ascending order through
// per-entry written flags, so no clearing sweep is needed and the block is ready
// directly out of reset. The result sits in an output register; while
// the receiver stalls, the block may accept one more item and holds it, ready to
// write back, until the waiting result is taken.
module generational_handle_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] slot_index_i,
  input  logic [30:0] handle_generation_i,
  input  logic        object_present_i,
  input  logic [31:0] object_ident_i,
  input  logic [7:0]  object_type_i,
  input  logic        type_registered_i,
  input  logic [31:0] type_contract_rights_i,
  input  logic [31:0] rights_value_i,
  input  logic [7:0]  expected_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [11:0] out_index_o,
  output logic [30:0] out_generation_o,
  output logic [31:0] out_rights_o,
  output logic [31:0] out_object_o,
  output logic [7:0]  out_type_o,
  output logic [12:0] live_count_o
);

  localparam int unsigned IW = ght_pkg::IDX_W;
  localparam int unsigned LW = ght_pkg::LINK_W;
  localparam int unsigned CW = ght_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CLR_RD,
    S_CLR_WR,
    S_FIN
  } state_e;

  state_e state_q;

  // Entry tables, each with one write port; the generation table has two read ports.
  logic [31:0] obj_mem   [ght_pkg::SLOTS];
  logic [7:0]  type_mem  [ght_pkg::SLOTS];
  logic [31:0] right_mem [ght_pkg::SLOTS];
  logic [30:0] gen_mem   [ght_pkg::SLOTS];
  logic [LW-1:0] link_mem [ght_pkg::SLOTS];

  // Per-entry flags; an entry whose generation or link was never written reads
  // as its reset value.
  logic [ght_pkg::SLOTS-1:0] live_q, gen_vld_q, link_vld_q;

  logic [LW-1:0] head_q;
  logic [CW-1:0] total_q;
  logic [4:0]    dup_bit_q;
  logic [IW-1:0] ctr_q;

  // Latched input item.
  logic [2:0]  mode_q;
  logic [31:0] sidx_q;
  logic [30:0] hgen_q;
  logic        present_q, registered_q;
  logic [31:0] ident_q, contract_q, rv_q;
  logic [7:0]  otype_q, want_q;

  // Registered read data.
  logic [31:0]   obj_a_q, rights_a_q;
  logic [7:0]    type_a_q;
  logic [30:0]   gen_a_q, gen_b_q;
  logic          gen_a_vld_q, gen_b_vld_q, link_b_vld_q;
  logic [LW-1:0] link_b_q;
  logic [IW-1:0] link_b_idx;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q;
  logic [11:0] oidx_q;
  logic [30:0] ogen_q;
  logic [31:0] orights_q, oobj_q;
  logic [7:0]  otype_out_q;
  logic [CW-1:0] ocnt_q;

  logic          accept, rd_en, out_free, exec_go, clr_wr;
  logic [IW-1:0] rd_addr, head_idx, sidx_idx;
  logic [30:0]   gen_a, gen_b, gen_clr;
  logic [LW-1:0] link_b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign rd_en       = accept || (state_q == S_CLR_RD);
  assign rd_addr     = (state_q == S_CLR_RD) ? ctr_q : slot_index_i[IW-1:0];
  assign head_idx    = head_q[IW-1:0];
  assign sidx_idx    = sidx_q[IW-1:0];
  assign out_free    = !out_valid_q || out_ready_i;
  assign exec_go     = (state_q == S_EXEC) && (mode_q != ght_pkg::MODE_CLEAR) && out_free;
  assign clr_wr      = (state_q == S_CLR_WR);

  // A result is loaded when an item resolves or a clear finishes; otherwise the
  // waiting result stays until the receiver takes it.
  assign out_valid_d = exec_go || (state_q == S_FIN && out_free) ||
                       (out_valid_q && !out_ready_i);

  assign gen_a      = gen_a_vld_q ? gen_a_q : '0;
  assign gen_b      = gen_b_vld_q ? gen_b_q : '0;
  assign link_b_idx = head_idx + IW'(1);
  assign link_b     = link_b_vld_q ? link_b_q
                                   : ((head_q == LW'(ght_pkg::SLOTS - 1)) ? ght_pkg::LINK_NONE
                                                                           : LW'(link_b_idx));

  // Operation decode.
  logic          hok, head_empty, alloc, do_close, rep_src;
  logic [2:0]    st;
  logic [31:0]   new_obj, grant_rights;
  logic [7:0]    new_type;
  logic          clr_live, clr_retire;

  assign head_empty = (head_q == ght_pkg::LINK_NONE);
  assign hok = (sidx_q < 32'(ght_pkg::SLOTS)) && live_q[sidx_idx] && (gen_a == hgen_q);

  always_comb begin
    st           = ght_pkg::ST_OK;
    alloc        = 1'b0;
    do_close     = 1'b0;
    rep_src      = 1'b0;
    new_obj      = obj_a_q;
    new_type     = type_a_q;
    grant_rights = rights_a_q & rv_q;
    case (mode_q)
      ght_pkg::MODE_CREATE: begin
        new_obj      = ident_q;
        new_type     = otype_q;
        grant_rights = rv_q;
        if (!present_q) st = ght_pkg::ST_NULL;
        else if (!registered_q) st = ght_pkg::ST_TYPE;
        else if ((rv_q & ~contract_q) != '0) st = ght_pkg::ST_RIGHTS;
        else if (head_empty) st = ght_pkg::ST_FULL;
        else alloc = 1'b1;
      end
      ght_pkg::MODE_CLOSE: begin
        if (!hok) st = ght_pkg::ST_INVALID;
        else begin
          do_close = 1'b1;
          rep_src  = 1'b1;
        end
      end
      ght_pkg::MODE_VERIFY: begin
        if (!hok) st = ght_pkg::ST_INVALID;
        else if (want_q != '0 && type_a_q != want_q) st = ght_pkg::ST_TYPE;
        else if ((rights_a_q & rv_q) != rv_q) st = ght_pkg::ST_RIGHTS;
        else rep_src = 1'b1;
      end
      ght_pkg::MODE_DUP: begin
        if (!hok) st = ght_pkg::ST_INVALID;
        else if (!rights_a_q[dup_bit_q]) st = ght_pkg::ST_RIGHTS;
        else if (head_empty) st = ght_pkg::ST_FULL;
        else alloc = 1'b1;
      end
      ght_pkg::MODE_INFO: begin
        if (!hok) st = ght_pkg::ST_INVALID;
        else rep_src = 1'b1;
      end
      ght_pkg::MODE_CLEAR: st = ght_pkg::ST_OK;
      default: st = ght_pkg::ST_INVALID;
    endcase
  end

  // Clear walk: a live slot has its generation raised unless at the cap.
  assign clr_live   = live_q[ctr_q];
  assign gen_clr    = (clr_live && gen_a != ght_pkg::GEN_CAP) ? gen_a + 31'd1 : gen_a;
  assign clr_retire = (gen_clr == ght_pkg::GEN_CAP);

  // Write-port selection.
  logic          gen_we, link_we, ent_we;
  logic [IW-1:0] gen_wa, link_wa;
  logic [30:0]   gen_wd;
  logic [LW-1:0] link_wd;

  assign ent_we = exec_go && alloc;

  always_comb begin
    gen_we  = 1'b0;
    gen_wa  = sidx_idx;
    gen_wd  = gen_a + 31'd1;
    link_we = 1'b0;
    link_wa = head_idx;
    link_wd = ght_pkg::LINK_NONE;
    if (clr_wr) begin
      gen_we  = clr_live;
      gen_wa  = ctr_q;
      gen_wd  = gen_clr;
      link_we = 1'b1;
      link_wa = ctr_q;
      link_wd = clr_retire ? ght_pkg::LINK_NONE : head_q;
    end else if (exec_go && alloc) begin
      link_we = 1'b1;
    end else if (exec_go && do_close) begin
      gen_we  = (gen_a != ght_pkg::GEN_CAP);
      link_we = 1'b1;
      link_wa = sidx_idx;
      link_wd = (gen_a == ght_pkg::GEN_CAP) ? ght_pkg::LINK_NONE : head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      obj_mem[head_idx]   <= new_obj;
      type_mem[head_idx]  <= new_type;
      right_mem[head_idx] <= grant_rights;
    end
    if (gen_we) gen_mem[gen_wa] <= gen_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (rd_en) begin
      obj_a_q    <= obj_mem[rd_addr];
      type_a_q   <= type_mem[rd_addr];
      rights_a_q <= right_mem[rd_addr];
      gen_a_q    <= gen_mem[rd_addr];
      gen_b_q    <= gen_mem[head_idx];
      link_b_q   <= link_mem[head_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      live_q       <= '0;
      gen_vld_q    <= '0;
      link_vld_q   <= '0;
      head_q       <= '0;
      total_q      <= '0;
      dup_bit_q    <= '0;
      ctr_q        <= '0;
      out_valid_q  <= 1'b0;
      gen_a_vld_q  <= 1'b0;
      gen_b_vld_q  <= 1'b0;
      link_b_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) dup_bit_q <= cfg_data_i;
      out_valid_q <= out_valid_d;
      if (gen_we) gen_vld_q[gen_wa] <= 1'b1;
      if (link_we) link_vld_q[link_wa] <= 1'b1;
      if (rd_en) begin
        gen_a_vld_q  <= gen_vld_q[rd_addr];
        gen_b_vld_q  <= gen_vld_q[head_idx];
        link_b_vld_q <= link_vld_q[head_idx];
      end
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (mode_q == ght_pkg::MODE_CLEAR) begin
            ctr_q   <= IW'(ght_pkg::SLOTS - 1);
            head_q  <= ght_pkg::LINK_NONE;
            total_q <= '0;
            state_q <= S_CLR_RD;
          end else if (out_free) begin
            if (alloc) begin
              live_q[head_idx] <= 1'b1;
              head_q  <= link_b;
              total_q <= total_q + CW'(1);
            end
            if (do_close) begin
              live_q[sidx_idx] <= 1'b0;
              total_q <= total_q - CW'(1);
              if (gen_a != ght_pkg::GEN_CAP) head_q <= LW'(sidx_idx);
            end
            state_q <= S_IDLE;
          end
        end
        S_CLR_RD: state_q <= S_CLR_WR;
        S_CLR_WR: begin
          live_q[ctr_q] <= 1'b0;
          if (!clr_retire) head_q <= LW'(ctr_q);
          if (ctr_q == '0) state_q <= S_FIN;
          else begin
            ctr_q   <= ctr_q - IW'(1);
            state_q <= S_CLR_RD;
          end
        end
        S_FIN: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item latch and result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q       <= mode_i;
      sidx_q       <= slot_index_i;
      hgen_q       <= handle_generation_i;
      present_q    <= object_present_i;
      ident_q      <= object_ident_i;
      otype_q      <= object_type_i;
      registered_q <= type_registered_i;
      contract_q   <= type_contract_rights_i;
      rv_q         <= rights_value_i;
      want_q       <= expected_type_i;
    end
    if (exec_go) begin
      status_q <= st;
      if (alloc) begin
        oidx_q      <= 12'(head_idx);
        ogen_q      <= gen_b;
        orights_q   <= grant_rights;
        oobj_q      <= new_obj;
        otype_out_q <= new_type;
        ocnt_q      <= total_q + CW'(1);
      end else if (rep_src) begin
        oidx_q      <= 12'(sidx_idx);
        ogen_q      <= gen_a;
        orights_q   <= rights_a_q;
        oobj_q      <= obj_a_q;
        otype_out_q <= type_a_q;
        ocnt_q      <= do_close ? (total_q - CW'(1)) : total_q;
      end else begin
        oidx_q      <= '0;
        ogen_q      <= '0;
        orights_q   <= '0;
        oobj_q      <= '0;
        otype_out_q <= '0;
        ocnt_q      <= total_q;
      end
    end else if (state_q == S_FIN && out_free) begin
      status_q    <= ght_pkg::ST_OK;
      oidx_q      <= '0;
      ogen_q      <= '0;
      orights_q   <= '0;
      oobj_q      <= '0;
      otype_out_q <= '0;
      ocnt_q      <= '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign out_index_o      = oidx_q;
  assign out_generation_o = ogen_q;
  assign out_rights_o     = orights_q;
  assign out_object_o     = oobj_q;
  assign out_type_o       = otype_out_q;
  assign live_count_o     = 13'(ocnt_q);

  // The live total never exceeds the table size.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(ght_pkg::SLOTS))
    else $error("live total exceeds table size");

  // While the block is idle, the free-list head never names a live slot.
  a_head_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && head_q != ght_pkg::LINK_NONE) |-> !live_q[head_idx])
    else $error("free-list head is live");

  // An accepted item blocks the input until it has been resolved.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second item accepted while busy");

  // After a clear walk the table holds no live slot.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> (live_q == '0 && total_q == '0))
    else $error("live slot left after clear");

endmodule
